// File: rtl/ufifo_pkg.sv
package ufifo_pkg;

  // Operation codes carried in the input word's tuser.
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LIST   = 2'd2;

  // Result codes carried in the output word's tuser.
  localparam logic [2:0] STATUS_INSERTED  = 3'd0;
  localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
  localparam logic [2:0] STATUS_FULL      = 3'd2;
  localparam logic [2:0] STATUS_REMOVED   = 3'd3;
  localparam logic [2:0] STATUS_EMPTY     = 3'd4;
  localparam logic [2:0] STATUS_ENTRY     = 3'd5;

  // Fixed field widths of the stream words.
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned STATUS_W = 3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                start;     // latch the accepted word, rewind the scan
    logic                rd_step;   // read the entry at the scan pointer, advance it
    logic                emit;      // load the output register
    logic [STATUS_W-1:0] status;    // result code for the output register
    logic                item_sel;  // 1: item is the entry read, 0: zero
    logic                last;      // last mark for the output register
    logic                ins_write; // append the latched value at the tail
    logic                pop;       // drop the head entry
  } ufifo_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [MODE_W-1:0] mode;      // latched operation
    logic              cnt_zero;  // queue is empty
    logic              full;      // queue holds DEPTH entries
    logic              scan_done; // every held entry has been read
    logic              pend;      // read data is valid for a compare
    logic              hit;       // read data equals the latched value
    logic              out_free;  // output register can take a word
  } ufifo_sts_t;

endpackage

// File: rtl/unique_value_fifo.sv
// The controller decodes each accepted input word; for a remove, a list or an insert into
// an empty queue it then loads the first result word into the output register, while an
// insert into a non-empty queue first searches the held entries (one compared per cycle).
// A list then adds one entry per cycle while the output register is free.
// One operation at a time; the next word is taken the cycle after the last result enters
// the output register; the entry-store read port paces the search and the listing.
// Synchronous active-high reset empties the queue; stored values are not cleared.
module unique_value_fifo #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] item
  output logic [2:0]  m_axis_tuser,   // [2:0] status
  output logic        m_axis_tlast
);
  import ufifo_pkg::*;

  ufifo_cmd_t cmd;
  ufifo_sts_t sts;

  // Operation sequencer.
  ufifo_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_axis_tvalid),
    .in_ready(s_axis_tready),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Entry store, pointers and output register.
  ufifo_datapath #(
    .DEPTH      (DEPTH),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (s_axis_tdata),
    .in_mode   (s_axis_tuser),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_item  (m_axis_tdata),
    .out_status(m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

// File: rtl/ufifo_ram.sv
module ufifo_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ufifo_datapath.sv
module ufifo_datapath #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ufifo_pkg::ufifo_cmd_t                 cmd,
  output ufifo_pkg::ufifo_sts_t                 sts,
  input  logic [ufifo_pkg::DATA_W-1:0]          in_data,
  input  logic [ufifo_pkg::MODE_W-1:0]          in_mode,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [ufifo_pkg::DATA_W-1:0]          out_item,
  output logic [ufifo_pkg::STATUS_W-1:0]        out_status,
  output logic                                  out_last
);
  import ufifo_pkg::*;

  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [MODE_W-1:0]      mode;
  logic [VALUE_WIDTH-1:0] value;
  logic [VALUE_WIDTH-1:0] value_in;
  logic [IW-1:0]          head;
  logic [IW-1:0]          tail;
  logic [IW-1:0]          pos;
  logic [CW-1:0]          count;
  logic [CW-1:0]          n;
  logic                   pend;
  logic [VALUE_WIDTH-1:0] rdata;
  logic [DATA_W-1:0]      item_ext;
  logic                   out_free;

  // Bring the 32-bit input to the stored width, and a stored entry back to 32 bits.
  generate
    if (VALUE_WIDTH > DATA_W) begin : g_wide
      assign value_in = {{(VALUE_WIDTH - DATA_W){in_data[DATA_W-1]}}, in_data};
      assign item_ext = rdata[DATA_W-1:0];
    end else if (VALUE_WIDTH == DATA_W) begin : g_same
      assign value_in = in_data;
      assign item_ext = rdata;
    end else begin : g_narrow
      assign value_in = in_data[VALUE_WIDTH-1:0];
      assign item_ext = {{(DATA_W - VALUE_WIDTH){1'b0}}, rdata};
    end
  endgenerate

  function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] p);
    ring_next = (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Entry store.
  ufifo_ram #(
    .WIDTH(VALUE_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (cmd.ins_write),
    .waddr(tail),
    .wdata(value),
    .re   (cmd.rd_step),
    .raddr(pos),
    .rdata(rdata)
  );

  // Latched operation and value.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode  <= in_mode;
      value <= value_in;
    end
  end

  // Ring pointers, fill count and scan position.
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
      pos   <= '0;
      n     <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= cmd.rd_step;
      if (cmd.start) begin
        pos <= head;
        n   <= '0;
      end else if (cmd.rd_step) begin
        pos <= ring_next(pos);
        n   <= n + 1'b1;
      end
      if (cmd.ins_write) begin
        tail  <= ring_next(tail);
        count <= count + 1'b1;
      end
      if (cmd.pop) begin
        head  <= ring_next(head);
        count <= count - 1'b1;
      end
    end
  end

  // Output register: the next word can be prepared while this one waits.
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= cmd.status;
      out_item   <= cmd.item_sel ? item_ext : '0;
      out_last   <= cmd.last;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts.mode      = mode;
    sts.cnt_zero  = (count == '0);
    sts.full      = (count == CW'(DEPTH));
    sts.scan_done = (n == count);
    sts.pend      = pend;
    sts.hit       = pend && (rdata == value);
    sts.out_free  = out_free;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("fill count exceeds depth");
  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> count != CW'(DEPTH))
    else $error("append while full");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    cmd.pop |-> count != '0)
    else $error("remove while empty");
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> out_free)
    else $error("output word overwritten");
`endif

endmodule

// File: rtl/ufifo_ctrl.sv
module ufifo_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ufifo_pkg::ufifo_sts_t sts,
  output ufifo_pkg::ufifo_cmd_t cmd
);
  import ufifo_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_DECODE  = 8'b0000_0010,
    ST_SEARCH  = 8'b0000_0100,
    ST_DUP     = 8'b0000_1000,
    ST_INS     = 8'b0001_0000,
    ST_EMPTY   = 8'b0010_0000,
    ST_RM_EMIT = 8'b0100_0000,
    ST_LS_EMIT = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  // Sequencing of one operation.
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (sts.mode)
          MODE_INSERT: begin
            if (sts.cnt_zero) begin
              state_next = ST_INS;
            end else begin
              cmd.rd_step = 1'b1;
              state_next  = ST_SEARCH;
            end
          end
          MODE_REMOVE: begin
            if (sts.cnt_zero) begin
              state_next = ST_EMPTY;
            end else begin
              cmd.rd_step = 1'b1;
              state_next  = ST_RM_EMIT;
            end
          end
          MODE_LIST: begin
            if (sts.cnt_zero) begin
              state_next = ST_EMPTY;
            end else begin
              cmd.rd_step = 1'b1;
              state_next  = ST_LS_EMIT;
            end
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      // One entry read and one compare per cycle, overlapped.
      ST_SEARCH: begin
        if (sts.hit) begin
          state_next = ST_DUP;
        end else if (sts.scan_done && !sts.pend) begin
          state_next = ST_INS;
        end else if (!sts.scan_done) begin
          cmd.rd_step = 1'b1;
        end
      end
      ST_DUP: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.status = STATUS_DUPLICATE;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_INS: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          cmd.last = 1'b1;
          if (sts.full) begin
            cmd.status = STATUS_FULL;
          end else begin
            cmd.status    = STATUS_INSERTED;
            cmd.ins_write = 1'b1;
          end
          state_next = ST_IDLE;
        end
      end
      ST_EMPTY: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          cmd.status = STATUS_EMPTY;
          cmd.last   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_RM_EMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.status   = STATUS_REMOVED;
          cmd.item_sel = 1'b1;
          cmd.last     = 1'b1;
          cmd.pop      = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      // Emit the entry just read and fetch the next one in the same cycle.
      ST_LS_EMIT: begin
        if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.status   = STATUS_ENTRY;
          cmd.item_sel = 1'b1;
          cmd.last     = sts.scan_done;
          if (sts.scan_done) begin
            state_next = ST_IDLE;
          end else begin
            cmd.rd_step = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> state == ST_DECODE)
    else $error("accepted word not decoded");
  a_write_ends: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> cmd.emit && cmd.status == STATUS_INSERTED)
    else $error("append without its result");
  a_single_op: assert property (@(posedge clk) disable iff (rst)
    !(cmd.ins_write && cmd.pop))
    else $error("append and remove together");
`endif

endmodule

// File: tb/sv/ufifo_result_check.sv
`timescale 1ns / 100ps

// Watches both stream channels of the unique-value FIFO, predicts the result
// words of every accepted operation and compares them with what comes out.
module ufifo_result_check #(
  parameter int unsigned DEPTH       = 16,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [1:0]  s_axis_tuser,   // [1:0] mode
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,   // [31:0] item
  input  logic [2:0]  m_axis_tuser,   // [2:0] status
  input  logic        m_axis_tlast,
  output int unsigned error_count,
  output int unsigned results_due
);

  import ufifo_pkg::*;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] item;
    logic        last;
  } fifo_result_t;

  // Shadow copy of the queue contents, head at index zero.
  logic [VALUE_WIDTH-1:0] held_values[$];
  // Result words still owed by the block, oldest first.
  fifo_result_t           awaited_results[$];
  int unsigned            mismatches;

  initial begin
    mismatches  = 0;
    error_count = 0;
    results_due = 0;
  end

  task automatic queue_result(input logic [2:0] status, input logic [31:0] item,
                              input logic last);
    fifo_result_t r;
    r.status = status;
    r.item   = item;
    r.last   = last;
    awaited_results.push_back(r);
  endtask

  // Update the shadow queue for one operation and record the words it causes.
  task automatic apply_operation(input logic [1:0] mode, input logic [31:0] value);
    logic [VALUE_WIDTH-1:0] kept;
    bit                     present;
    kept    = VALUE_WIDTH'(signed'(value));
    present = 1'b0;
    case (mode)
      MODE_INSERT: begin
        foreach (held_values[i]) begin
          if (held_values[i] == kept) present = 1'b1;
        end
        // The duplicate search wins over the full check.
        if (present) begin
          queue_result(STATUS_DUPLICATE, '0, 1'b1);
        end else if (held_values.size() >= DEPTH) begin
          queue_result(STATUS_FULL, '0, 1'b1);
        end else begin
          held_values.push_back(kept);
          queue_result(STATUS_INSERTED, '0, 1'b1);
        end
      end
      MODE_REMOVE: begin
        if (held_values.size() == 0) begin
          queue_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          queue_result(STATUS_REMOVED, 32'(held_values[0]), 1'b1);
          void'(held_values.pop_front());
        end
      end
      MODE_LIST: begin
        if (held_values.size() == 0) begin
          queue_result(STATUS_EMPTY, '0, 1'b1);
        end else begin
          foreach (held_values[i]) begin
            queue_result(STATUS_ENTRY, 32'(held_values[i]), i == held_values.size() - 1);
          end
        end
      end
      default: ;  // the spare mode code is dropped without a result
    endcase
  endtask

  // Sample both channels on the rising edge.
  always @(posedge clk) begin
    fifo_result_t want;
    if (rst) begin
      held_values.delete();
      awaited_results.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        apply_operation(s_axis_tuser, s_axis_tdata);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (awaited_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected word: status %0d item %h last %0d", $realtime,
                     m_axis_tuser, m_axis_tdata, m_axis_tlast);
          end
        end else begin
          want = awaited_results.pop_front();
          if (m_axis_tuser !== want.status || m_axis_tdata !== want.item ||
              m_axis_tlast !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: mismatch: expected status %0d item %h last %0d, got %0d %h %0d",
                       $realtime, want.status, want.item, want.last,
                       m_axis_tuser, m_axis_tdata, m_axis_tlast);
            end
          end
        end
      end
    end
    error_count <= mismatches;
    results_due <= awaited_results.size();
  end

endmodule

// File: tb/sv/tb_unique_value_fifo.sv
`timescale 1ns / 100ps

module tb_unique_value_fifo;

  import ufifo_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RAND_OPS    = 345;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 40;
  localparam int unsigned POOL_SIZE   = 24;
  // Mode code the block must ignore.
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic [1:0]  s_axis_tuser = '0;   // [1:0] mode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;        // [31:0] item
  logic [2:0]  m_axis_tuser;        // [2:0] status
  logic        m_axis_tlast;

  int unsigned error_count;
  int unsigned results_due;
  int unsigned cycle_count;
  bit          calm = 1'b0;
  logic [31:0] value_pool[POOL_SIZE];

  always #4 clk = ~clk;

  unique_value_fifo #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  ufifo_result_check #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) result_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .error_count   (error_count),
    .results_due   (results_due)
  );

  // The receiver stalls now and then, except during the calm stretch.
  always @(negedge clk) begin
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 9);
  end

  // Hard stop if the run hangs.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // Present one word at a falling edge, with an occasional gap first, and hold
  // it until the block takes it.
  task automatic issue_operation(input logic [1:0] mode, input logic [31:0] value);
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 9) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= value;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
  endtask

  initial begin
    int unsigned issued;
    int unsigned roll;
    int unsigned insert_share;
    logic [31:0] value;

    foreach (value_pool[i]) value_pool[i] = $urandom;
    value_pool[0] = 32'h7FFF_FFFF;
    value_pool[1] = 32'h8000_0000;
    value_pool[2] = 32'h0000_0000;
    value_pool[3] = 32'hFFFF_FFFF;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part: empty cases, extreme values, duplicates, the spare mode
    // and a queue filled to the brim.
    issue_operation(MODE_LIST, 32'h0);
    issue_operation(MODE_REMOVE, 32'hFFFF_FFFF);
    issue_operation(MODE_INSERT, 32'h7FFF_FFFF);
    issue_operation(MODE_INSERT, 32'h8000_0000);
    issue_operation(MODE_INSERT, 32'h0000_0000);
    issue_operation(MODE_INSERT, 32'hFFFF_FFFF);
    issue_operation(MODE_INSERT, 32'h7FFF_FFFF);
    issue_operation(MODE_LIST, 32'h5555_AAAA);
    issue_operation(MODE_UNUSED, 32'h1234_5678);
    issue_operation(MODE_REMOVE, 32'h0);
    for (int k = 0; k < 13; k++) begin
      issue_operation(MODE_INSERT, 32'hA5A5_0000 + k);
    end
    issue_operation(MODE_INSERT, 32'h0BAD_F00D);
    // Duplicate while full still reports a duplicate.
    issue_operation(MODE_INSERT, 32'h8000_0000);
    issue_operation(MODE_LIST, 32'h0);
    issue_operation(MODE_REMOVE, 32'h0);

    // Random part: the insert share drifts so the queue swings between empty
    // and full; half of the values come from a small pool to provoke duplicates.
    issued       = 0;
    insert_share = 60;
    while (issued < RAND_OPS) begin
      calm = (issued >= 150 && issued < 230);
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        issue_operation(MODE_UNUSED, $urandom);
      end else begin
        if (roll < 13) begin
          issue_operation(MODE_LIST, $urandom);
        end else if ($urandom_range(0, 99) < insert_share) begin
          value = $urandom_range(0, 1) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                       : $urandom;
          issue_operation(MODE_INSERT, value);
        end else begin
          issue_operation(MODE_REMOVE, $urandom);
        end
        issued++;
        if (issued % 40 == 0) insert_share = $urandom_range(25, 85);
      end
    end
    calm = 1'b0;

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
